[src/char_lcd_nibble_command_serializer_core_macros.svh]
// Assertion macros shared by the LCD command serializer RTL.
`ifndef CHAR_LCD_NIBBLE_COMMAND_SERIALIZER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_COMMAND_SERIALIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define CLNC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serializer check failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define CLNC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serializer check failed");
`else
`define CLNC_ASSERT_NOW(lbl, ante, cons)
`define CLNC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/clnc_pkg.sv]
// Types, constants and microcode ROM of the LCD command serializer.
`timescale 1ns / 1ps
package clnc_pkg;

    // Default geometry of the display
    localparam int ROW_COUNT_DEF = 4;
    localparam int COL_COUNT_DEF = 20;

    // Command codes
    localparam logic [1:0] CMD_CHAR   = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_CURSOR = 2'd2;
    localparam logic [1:0] CMD_NUMBER = 2'd3;

    // LCD instruction bytes and masks
    localparam logic [7:0] INSTR_CLEAR  = 8'h01;
    localparam logic [3:0] ASCII_DIGIT  = 4'h3;

    // Decimal conversion: q = (n * RECIP_10) >> RECIP_SHIFT for 16-bit n
    localparam logic [15:0] RECIP_10    = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [15:0] TEN         = 16'd10;
    localparam int          DIGITS      = 5;
    localparam int          CNT_W       = $clog2(DIGITS + 1);

    // Microcode address width and entry points
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] UA_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] UA_CONV = 4'd1;
    localparam logic [UPC_W-1:0] UA_POP  = 4'd2;
    localparam logic [UPC_W-1:0] UA_EMIT = 4'd3;
    localparam logic [UPC_W-1:0] UA_ERR  = 4'd9;

    // Datapath operation of one microcode step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CONV,
        OP_POP,
        OP_EMIT,
        OP_ERR
    } op_t;

    // Jump condition of one microcode step
    typedef enum logic [1:0] {
        J_NONE,
        J_DISPATCH,
        J_QNZ,
        J_CNT
    } jmp_t;

    // One control word
    typedef struct packed {
        op_t              op;
        jmp_t             jmp;
        logic [UPC_W-1:0] target;
        logic             done;
        logic             nib_lo;
        logic             en;
        logic             last_step;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        logic fire;
        op_t  op;
        logic nib_lo;
        logic en;
        logic last_step;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic out_free;
        logic q_nz;
        logic cnt_nz;
        logic bad;
    } stat_t;

    // Line base addresses of the display RAM
    function automatic logic [6:0] line_base(input logic [1:0] r);
        logic [6:0] b;
        case (r)
            2'd0:    b = 7'h00;
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h14;
            2'd3:    b = 7'h54;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

    // Microcode program
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, jmp: J_NONE, target: UA_IDLE, done: 1'b1,
              nib_lo: 1'b0, en: 1'b0, last_step: 1'b0};
        case (addr)
            // wait for a command, then branch on its kind
            4'd0: begin
                w.op = OP_ACCEPT; w.jmp = J_DISPATCH; w.done = 1'b0;
            end
            // one decimal digit per pass, loop until the quotient is zero
            4'd1: begin
                w.op = OP_CONV; w.jmp = J_QNZ; w.target = UA_CONV; w.done = 1'b0;
            end
            // most significant pending digit into the byte register
            4'd2: begin
                w.op = OP_POP; w.done = 1'b0;
            end
            // high nibble: plain, strobe, release
            4'd3: begin
                w.op = OP_EMIT; w.done = 1'b0;
            end
            4'd4: begin
                w.op = OP_EMIT; w.en = 1'b1; w.done = 1'b0;
            end
            4'd5: begin
                w.op = OP_EMIT; w.done = 1'b0;
            end
            // low nibble: plain, strobe, release
            4'd6: begin
                w.op = OP_EMIT; w.nib_lo = 1'b1; w.done = 1'b0;
            end
            4'd7: begin
                w.op = OP_EMIT; w.nib_lo = 1'b1; w.en = 1'b1; w.done = 1'b0;
            end
            4'd8: begin
                w.op = OP_EMIT; w.nib_lo = 1'b1; w.last_step = 1'b1;
                w.jmp = J_CNT; w.target = UA_POP;
            end
            // rejected cursor position
            4'd9: begin
                w.op = OP_ERR;
            end
            default: begin
                w.op = OP_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

[src/clnc_sequencer.sv]
// Microcode step counter, control ROM and jump logic.
`timescale 1ns / 1ps
module clnc_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      command,
    input  clnc_pkg::stat_t stat,
    output logic            in_stall,
    output clnc_pkg::ctrl_t ctrl
);
    import clnc_pkg::*;

    logic [UPC_W-1:0] pc_reg;
    logic [UPC_W-1:0] pc_next;
    uword_t           uw;
    logic             hold;
    logic             taken;

    // Current control word
    assign uw = ucode(pc_reg);

    // A step holds while its channel is not ready
    always_comb
    begin
        hold = 1'b0;
        case (uw.op)
            OP_ACCEPT: hold = !in_valid;
            OP_EMIT:   hold = !stat.out_free;
            OP_ERR:    hold = !stat.out_free;
            default:   hold = 1'b0;
        endcase
    end

    // Conditional jumps
    always_comb
    begin
        case (uw.jmp)
            J_QNZ:   taken = stat.q_nz;
            J_CNT:   taken = stat.cnt_nz;
            default: taken = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        if (hold)
            pc_next = pc_reg;
        else if (uw.jmp == J_DISPATCH)
        begin
            if (command == CMD_NUMBER)
                pc_next = UA_CONV;
            else if (command == CMD_CURSOR && stat.bad)
                pc_next = UA_ERR;
            else
                pc_next = UA_EMIT;
        end
        else if (taken)
            pc_next = uw.target;
        else if (uw.done)
            pc_next = UA_IDLE;
        else
            pc_next = pc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= UA_IDLE;
        else
            pc_reg <= pc_next;
    end

    // Control to the datapath
    assign in_stall       = (uw.op != OP_ACCEPT);
    assign ctrl.fire      = !hold;
    assign ctrl.op        = uw.op;
    assign ctrl.nib_lo    = uw.nib_lo;
    assign ctrl.en        = uw.en;
    assign ctrl.last_step = uw.last_step;

endmodule

[src/clnc_datapath.sv]
// Byte register, decimal digit stack and output register.
`timescale 1ns / 1ps
module clnc_datapath #(
    parameter int ROW_COUNT = clnc_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT = clnc_pkg::COL_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  clnc_pkg::ctrl_t ctrl,
    input  logic            backlight,
    input  logic [1:0]      command,
    input  logic [7:0]      char_code,
    input  logic [2:0]      row,
    input  logic [4:0]      column,
    input  logic [15:0]     number,
    input  logic            out_stall,
    output clnc_pkg::stat_t stat,
    output logic            out_valid,
    output logic [7:0]      expander_byte,
    output logic            bad_position,
    output logic            last
);
    import clnc_pkg::*;

    logic [7:0]       byte_reg, byte_next;
    logic             rs_reg, rs_next;
    logic [15:0]      num_reg, num_next;
    logic [3:0]       dig_reg [DIGITS];
    logic [3:0]       dig_next [DIGITS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_bad_reg, out_bad_next;
    logic             out_last_reg, out_last_next;

    logic [31:0]      prod;
    logic [12:0]      quot;
    logic [15:0]      quot_x10;
    logic [15:0]      rem_full;
    logic [6:0]       cursor_addr;
    logic [7:0]       cmd_byte;
    logic             cmd_rs;
    logic [3:0]       nib;

    // Divide by ten through the reciprocal
    assign prod     = 32'(num_reg) * 32'(RECIP_10);
    assign quot     = prod[31:RECIP_SHIFT];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem_full = num_reg - quot_x10;

    // Status
    assign stat.out_free = !out_valid_reg || !out_stall;
    assign stat.q_nz     = (num_reg >= TEN);
    assign stat.cnt_nz   = (cnt_reg != '0);
    assign stat.bad      = (row >= 3'(ROW_COUNT)) || (column >= 5'(COL_COUNT));

    // LCD byte for the incoming command
    assign cursor_addr = line_base(row[1:0]) + {2'b00, column};
    always_comb
    begin
        case (command)
            CMD_CHAR:
            begin
                cmd_byte = char_code;
                cmd_rs   = 1'b1;
            end
            CMD_CLEAR:
            begin
                cmd_byte = INSTR_CLEAR;
                cmd_rs   = 1'b0;
            end
            CMD_CURSOR:
            begin
                cmd_byte = {1'b1, cursor_addr};
                cmd_rs   = 1'b0;
            end
            default:
            begin
                cmd_byte = byte_reg;
                cmd_rs   = 1'b1;
            end
        endcase
    end

    assign nib = ctrl.nib_lo ? byte_reg[3:0] : byte_reg[7:4];

    // Working registers
    always_comb
    begin
        byte_next = byte_reg;
        rs_next   = rs_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        for (int i = 0; i < DIGITS; i++)
            dig_next[i] = dig_reg[i];
        if (ctrl.fire)
        begin
            case (ctrl.op)
                OP_ACCEPT:
                begin
                    byte_next = cmd_byte;
                    rs_next   = cmd_rs;
                    num_next  = number;
                    cnt_next  = '0;
                end
                OP_CONV:
                begin
                    dig_next[0] = rem_full[3:0];
                    for (int i = 1; i < DIGITS; i++)
                        dig_next[i] = dig_reg[i-1];
                    num_next = {3'b000, quot};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                OP_POP:
                begin
                    byte_next = {ASCII_DIGIT, dig_reg[0]};
                    rs_next   = 1'b1;
                    for (int i = 0; i < DIGITS - 1; i++)
                        dig_next[i] = dig_reg[i+1];
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                default:
                begin
                    byte_next = byte_reg;
                end
            endcase
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        out_bad_next   = out_bad_reg;
        out_last_next  = out_last_reg;
        if (ctrl.fire && ctrl.op == OP_EMIT)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = {nib, backlight, ctrl.en, 1'b0, rs_reg};
            out_bad_next   = 1'b0;
            out_last_next  = ctrl.last_step && (cnt_reg == '0);
        end
        else if (ctrl.fire && ctrl.op == OP_ERR)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = 8'h00;
            out_bad_next   = 1'b1;
            out_last_next  = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        rs_reg       <= rs_next;
        num_reg      <= num_next;
        out_byte_reg <= out_byte_next;
        out_bad_reg  <= out_bad_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < DIGITS; i++)
            dig_reg[i] <= dig_next[i];
    end

    assign out_valid     = out_valid_reg;
    assign expander_byte = out_byte_reg;
    assign bad_position  = out_bad_reg;
    assign last          = out_last_reg;

endmodule

[src/char_lcd_nibble_command_serializer_core.sv]
// Top level of the 4-bit character LCD command serializer.
//
// Input channel (in_valid / in_stall): one display command per transaction:
// write character, clear, set cursor or write a 16-bit number in decimal.
// Output channel (out_valid / out_stall): one port expander byte per
// transaction; last marks the final byte of a command's run, and a rejected
// cursor position gives a single byte 0x00 with bad_position and last set.
// Each LCD byte becomes six expander bytes (high nibble plain, strobed,
// released, then the same for the low nibble). cfg_write/cfg_data set the
// backlight bit placed in bit 3 of every byte but the error byte.
// Timing: a microcoded sequencer runs one step per cycle unless a step holds
// for its input or output channel. Character, clear and cursor commands run
// an accept step and six byte steps; a rejected cursor runs an accept step
// and an error step. A number of d digits (d = 1..5) runs the accept step,
// one divide-by-ten step per digit, then per digit a fetch step and six byte
// steps. The first byte enters the output register at the first emit step.
// A new command is taken once the previous run is in the output register.
// Reset clears the sequencer and output valid and sets the backlight bit.
// A stall on the output freezes the sequencer at its emit or error step; no
// byte is lost or repeated.
`timescale 1ns / 1ps
module char_lcd_nibble_command_serializer_core #(
    parameter int ROW_COUNT = clnc_pkg::ROW_COUNT_DEF,
    parameter int COL_COUNT = clnc_pkg::COL_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  char_code,
    input  logic [2:0]  row,
    input  logic [4:0]  column,
    input  logic [15:0] number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  expander_byte,
    output logic        bad_position,
    output logic        last
);
    import clnc_pkg::*;

`include "char_lcd_nibble_command_serializer_core_macros.svh"

    logic  backlight_reg;
    ctrl_t ctrl;
    stat_t stat;

    // Backlight register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            backlight_reg <= 1'b1;
        else if (cfg_write)
            backlight_reg <= cfg_data;
    end

    // Control sequencer
    clnc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .stat     (stat),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    // Datapath
    clnc_datapath #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .backlight     (backlight_reg),
        .command       (command),
        .char_code     (char_code),
        .row           (row),
        .column        (column),
        .number        (number),
        .out_stall     (out_stall),
        .stat          (stat),
        .out_valid     (out_valid),
        .expander_byte (expander_byte),
        .bad_position  (bad_position),
        .last          (last)
    );

    // An error result is a lone zero byte that ends its run
    `CLNC_ASSERT_NOW(a_err_is_last, out_valid && bad_position, last && expander_byte == 8'h00)
    // A strobed byte never ends a run nor reports an error
    `CLNC_ASSERT_NOW(a_strobe_mid_run, out_valid && expander_byte[2], !last && !bad_position)
    // After a command is taken the sequencer leaves the accept step
    `CLNC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule
